// ----- hdl/pls_pkg.sv -----
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants for the positional list store: opcodes, result
// status codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

    localparam int DATA_W           = 32;
    localparam int POS_W            = 8;
    localparam int OP_W             = 3;
    localparam int STATUS_W         = 2;
    localparam int CNT_OUT_W        = 5;
    localparam int S_TDATA_W        = 40;
    localparam int M_TDATA_W        = 40;
    localparam int DEFAULT_CAPACITY = 16;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FIRST = 3'd0,
        OP_INS_LAST  = 3'd1,
        OP_DEL_FIRST = 3'd2,
        OP_DEL_LAST  = 3'd3,
        OP_INS_AT    = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_DUMP      = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_INS      = 6'b000010,
        ST_DEL      = 6'b000100,
        ST_DUMP_RD  = 6'b001000,
        ST_DUMP_OUT = 6'b010000,
        ST_FINISH   = 6'b100000
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/pls_store.sv -----
// ----------------------------------------------------------------------------
// pls_store
// Element memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_store
    import pls_pkg::*;
#(
    parameter int DEPTH = DEFAULT_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/positional_list_store.sv -----
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of signed 32-bit values with insert, delete and dump by
// position, kept densely in list order in a single-port-write memory.
// ----------------------------------------------------------------------------
// Each transfer on the s_ side carries one operation; the block takes one
// operation at a time and drops s_tready until its last result is loaded into
// the output register. Every entry that an insert or delete moves goes through
// the memory's single read and write port, one entry per cycle, after which
// the new value is written (insert) or the count is dropped (delete) and the
// result is loaded; a rejected operation goes straight to its result. The
// longest shifts, CAPACITY - 1 entries each, are an insert at the front of a
// list holding CAPACITY - 1 entries and a delete at the front of a full list.
// Each result waits while the output register is held by m_tready low.
// A dump reads each entry in ST_DUMP_RD, loads it in ST_DUMP_OUT and gives one
// transfer per entry on the m_ side, with m_tlast on the final one; an empty
// list gives one transfer. m_tuser carries the status; count is reported modulo 32.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store
    import pls_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // value[31:0], position[39:32]
    input  wire logic [OP_W-1:0]      s_tuser,   // opcode[2:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // count[4:0], element[36:5], zero pad
    output logic      [STATUS_W-1:0]  m_tuser,   // status[1:0]
    output logic                      m_tlast
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int CMP_W = CW + POS_W;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     wa_reg, wa_next;
    logic              pend_reg, pend_next;
    logic [DATA_W-1:0] val_reg, val_next;
    status_t           res_reg, res_next;

    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [CW-1:0]     out_count_reg, out_count_next;
    logic [DATA_W-1:0] out_elem_reg, out_elem_next;
    logic              out_last_reg, out_last_next;
    logic              out_load, out_free;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata, mem_rdata;

    op_t               s_op;
    logic [DATA_W-1:0] s_value;
    logic [POS_W-1:0]  s_pos;
    logic [CMP_W-1:0]  pos_c, cnt_c;
    logic [CW-1:0]     ptr_inc;
    logic [CW+4:0]     out_count_ext;
    logic              list_full, list_empty;

    assign s_op       = op_t'(s_tuser);
    assign s_value    = s_tdata[DATA_W-1:0];
    assign s_pos      = s_tdata[DATA_W+POS_W-1:DATA_W];
    assign pos_c      = CMP_W'(s_pos);
    assign cnt_c      = CMP_W'(count_reg);
    assign ptr_inc    = ptr_reg + 1'b1;
    assign list_full  = (count_reg == CW'(CAPACITY));
    assign list_empty = (count_reg == '0);
    assign out_free   = !out_valid_reg || m_tready;

    pls_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        idx_next        = idx_reg;
        wa_next         = wa_reg;
        pend_next       = 1'b0;
        val_next        = val_reg;
        res_next        = res_reg;
        mem_we          = pend_reg;
        mem_waddr       = wa_reg;
        mem_wdata       = mem_rdata;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_elem_next   = out_elem_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    val_next = s_value;
                    case (s_op)
                        OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
                            if (list_full) begin
                                res_next   = STAT_FULL;
                                state_next = ST_FINISH;
                            end else if (s_op == OP_INS_AT &&
                                         (pos_c == '0 || pos_c > cnt_c + 1'b1)) begin
                                res_next   = STAT_BADPOS;
                                state_next = ST_FINISH;
                            end else begin
                                if (s_op == OP_INS_FIRST) begin
                                    idx_next = '0;
                                end else if (s_op == OP_INS_LAST) begin
                                    idx_next = count_reg;
                                end else begin
                                    idx_next = CW'(pos_c - 1'b1);
                                end
                                ptr_next   = count_reg;
                                state_next = ST_INS;
                            end
                        end
                        OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
                            if (list_empty) begin
                                res_next   = STAT_EMPTY;
                                state_next = ST_FINISH;
                            end else if (s_op == OP_DEL_AT &&
                                         (pos_c == '0 || pos_c > cnt_c)) begin
                                res_next   = STAT_BADPOS;
                                state_next = ST_FINISH;
                            end else begin
                                if (s_op == OP_DEL_FIRST) begin
                                    ptr_next = '0;
                                end else if (s_op == OP_DEL_LAST) begin
                                    ptr_next = count_reg - 1'b1;
                                end else begin
                                    ptr_next = CW'(pos_c - 1'b1);
                                end
                                state_next = ST_DEL;
                            end
                        end
                        OP_DUMP: begin
                            if (list_empty) begin
                                res_next   = STAT_EMPTY;
                                state_next = ST_FINISH;
                            end else begin
                                ptr_next   = '0;
                                state_next = ST_DUMP_RD;
                            end
                        end
                        default: begin
                            res_next   = STAT_OK;
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_INS: begin
                // walk down from the tail, moving each entry one slot up
                if (ptr_reg > idx_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(ptr_reg - 1'b1);
                    wa_next   = ptr_reg[AW-1:0];
                    ptr_next  = ptr_reg - 1'b1;
                    pend_next = 1'b1;
                end else if (!pend_reg) begin
                    mem_we     = 1'b1;
                    mem_waddr  = idx_reg[AW-1:0];
                    mem_wdata  = val_reg;
                    count_next = count_reg + 1'b1;
                    res_next   = STAT_OK;
                    state_next = ST_FINISH;
                end
            end
            ST_DEL: begin
                // walk up from the hole, moving each entry one slot down
                if (ptr_inc < count_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_inc[AW-1:0];
                    wa_next   = ptr_reg[AW-1:0];
                    ptr_next  = ptr_inc;
                    pend_next = 1'b1;
                end else if (!pend_reg) begin
                    count_next = count_reg - 1'b1;
                    res_next   = STAT_OK;
                    state_next = ST_FINISH;
                end
            end
            ST_DUMP_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = ptr_reg[AW-1:0];
                state_next = ST_DUMP_OUT;
            end
            ST_DUMP_OUT: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_status_next = STAT_OK;
                    out_count_next  = count_reg;
                    out_elem_next   = mem_rdata;
                    out_last_next   = (ptr_inc == count_reg);
                    if (ptr_inc == count_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        ptr_next   = ptr_inc;
                        state_next = ST_DUMP_RD;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_status_next = res_reg;
                    out_count_next  = count_reg;
                    out_elem_next   = '0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg        <= ptr_next;
        idx_reg        <= idx_next;
        wa_reg         <= wa_next;
        val_reg        <= val_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_elem_reg   <= out_elem_next;
        out_last_reg   <= out_last_next;
    end

    assign out_count_ext = (CW + 5)'(out_count_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_elem_reg, out_count_ext[CNT_OUT_W-1:0]});
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("list count above capacity");

    a_write_in_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_INS || state_reg == ST_DEL))
        else $error("memory write outside insert or delete");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && count_reg != $past(count_reg)) |->
            ($past(state_reg == ST_INS || state_reg == ST_DEL) &&
             (count_reg == $past(count_reg) + 1'b1 ||
              count_reg == $past(count_reg) - 1'b1)))
        else $error("count changed outside a finished insert or delete");

    a_dump_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP_OUT) |-> (ptr_reg < count_reg))
        else $error("dump pointer beyond list end");

endmodule

`default_nettype wire
